// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define SKF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also checks through reset
`define SKF_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Types, widths and constants of the scalar Kalman speed filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Default number of filtered channels
    localparam int CHANNELS_DEF = 4;

    // Fixed-point widths
    localparam int FRAC  = 16;          // fraction bits of Q16.16
    localparam int P_W   = 40;          // kept variance, unsigned Q24.16
    localparam int X_W   = 32;          // kept estimate, signed Q16.16
    localparam int D_W   = X_W + 1;     // innovation z - x
    localparam int K_W   = FRAC + 1;    // gain, 0 .. 1.0
    localparam int DEN_W = P_W + 1;     // p + r
    localparam int REM_W = DEN_W + 1;   // divider partial remainder
    localparam int MA_W  = P_W + 1;     // shared multiplier, operand a (signed)
    localparam int MB_W  = K_W + 1;     // shared multiplier, operand b (signed)
    localparam int PR_W  = MA_W + MB_W; // product

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = K_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [31:0]    Q_RESET    = 32'd1966080;   // 30.0
    localparam logic [31:0]    R_RESET    = 32'd19660800;  // 300.0
    localparam logic [3:0]     MASK_RESET = 4'd5;
    localparam logic [P_W-1:0] VAR_RESET  = P_W'(65536);   // 1.0
    localparam logic [P_W-1:0] P_MAX      = '1;
    localparam logic [K_W-1:0] K_ONE      = K_W'(65536);

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PROCESS_NOISE  = 2'd0;
    localparam logic [1:0] REG_MEASURE_NOISE  = 2'd1;
    localparam logic [1:0] REG_DIRECTION_MASK = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] raw_delta;
    } in_item_t;

    // Result word
    typedef struct packed {
        logic [1:0]         out_channel;
        logic signed [15:0] filtered_speed;
    } out_item_t;

endpackage

// ----- sv/scalar_kalman_speed_filter.sv -----
// ----------------------------------------------------------------------------
// An accepted input word passes through these steps before the next word is
// taken: capture it, fetch and bump the channel variance, form the gain
// denominator and innovation, 17 steps of a restoring divider that produces
// the Q1.16 gain one bit per cycle, two passes through one shared 41x18
// multiplier (estimate update, then variance update), a write-back and a
// hand-off into the result register. Results sit in an output register, so
// the next word is taken while a result waits; only a second finished result
// stalls until the first is taken. A word for a channel beyond CHANNELS
// leaves the per-channel filter state alone, skips the divider and multiplier
// steps and returns a filtered_speed of zero through the result register.
// ----------------------------------------------------------------------------
// scalar_kalman_speed_filter
// Per-channel one-dimensional Kalman filter on encoder delta samples.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scalar_kalman_speed_filter
    import skf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // sample input
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    // filtered result
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOAD  = 8'b0000_0010,
        ST_DENOM = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_MULK  = 8'b0001_0000,
        ST_UPDX  = 8'b0010_0000,
        ST_UPDP  = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [3:0]  mask_reg;

    // per-channel filter state
    logic signed [X_W-1:0] est_reg [CHANNELS];
    logic [P_W-1:0]        var_reg [CHANNELS];

    // working registers
    logic [1:0]            ch_reg;
    logic signed [15:0]    z_reg;
    logic signed [X_W-1:0] x_reg;
    logic [P_W-1:0]        p_reg;
    logic [DEN_W-1:0]      den_reg;
    logic signed [D_W-1:0] diff_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [K_W-1:0]        k_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic signed [PR_W-1:0] prod_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    // combinational
    logic                   in_fire;
    logic                   out_load;
    logic [CH_W-1:0]        idx;
    logic                   ch_ok;
    logic signed [15:0]     z_in;
    logic signed [X_W-1:0]  x_rd;
    logic [P_W-1:0]         var_rd;
    logic [DEN_W-1:0]       p_sum;
    logic [P_W-1:0]         p_sat;
    logic [DEN_W-1:0]       den_sum;
    logic signed [X_W-1:0]  z_q;
    logic signed [D_W-1:0]  diff_next;
    logic [REM_W-1:0]       trial;
    logic                   q_bit;
    logic [REM_W-1:0]       rem_next;
    logic                   div_last;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PR_W-1:0] mul_p;
    logic signed [X_W-1:0]  x_new;
    logic [P_W-1:0]         var_new;
    logic signed [15:0]     res;

    assign in_fire   = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_load  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // channel lookup, guarded against channels without a filter
    assign idx    = CH_W'(ch_reg);
    assign ch_ok  = ({30'd0, ch_reg} < 32'(CHANNELS));
    assign x_rd   = ch_ok ? est_reg[idx] : '0;
    assign var_rd = ch_ok ? var_reg[idx] : '0;

    // direction sign, negation of the minimum saturates
    always_comb begin
        z_in = s_data.raw_delta;
        if (mask_reg[s_data.channel]) begin
            z_in = (s_data.raw_delta == 16'sh8000) ? 16'sh7fff : -s_data.raw_delta;
        end
    end

    // p + q, saturating at the 40-bit ceiling
    assign p_sum = {1'b0, var_rd} + {{(DEN_W-32){1'b0}}, q_reg};
    assign p_sat = p_sum[DEN_W-1] ? P_MAX : p_sum[P_W-1:0];

    // denominator and innovation
    assign den_sum   = {1'b0, p_reg} + {{(DEN_W-32){1'b0}}, r_reg};
    assign z_q       = {z_reg, {FRAC{1'b0}}};
    assign diff_next = {z_q[X_W-1], z_q} - {x_reg[X_W-1], x_reg};

    // restoring divider step: first step tests bit 16 unshifted
    assign trial    = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign q_bit    = (trial >= {1'b0, den_reg});
    assign rem_next = q_bit ? (trial - {1'b0, den_reg}) : trial;
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // shared multiplier: k*(z-x), then p*(1-k)
    always_comb begin
        if (state_reg == ST_MULK) begin
            mul_a = {{(MA_W-D_W){diff_reg[D_W-1]}}, diff_reg};
            mul_b = {1'b0, k_reg};
        end else begin
            mul_a = {1'b0, p_reg};
            mul_b = {1'b0, K_ONE - k_reg};
        end
    end
    assign mul_p = mul_a * mul_b;

    // floor shifts of the products; both results fit their kept widths
    assign x_new   = x_reg + prod_reg[X_W+FRAC-1:FRAC];
    assign var_new = prod_reg[P_W+FRAC-1:FRAC];

    // estimate truncated toward zero, always inside 16-bit range
    assign res = x_reg[X_W-1:FRAC] +
                 16'((x_reg[X_W-1] && (x_reg[FRAC-1:0] != '0)) ? 1 : 0);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_LOAD;
            ST_LOAD:  state_next = ch_ok ? ST_DENOM : ST_FIN;
            ST_DENOM: state_next = ST_DIV;
            ST_DIV:   if (div_last) state_next = ST_MULK;
            ST_MULK:  state_next = ST_UPDX;
            ST_UPDX:  state_next = ST_UPDP;
            ST_UPDP:  state_next = ST_FIN;
            ST_FIN:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control, configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            q_reg       <= Q_RESET;
            r_reg       <= R_RESET;
            mask_reg    <= MASK_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                est_reg[i] <= '0;
                var_reg[i] <= VAR_RESET;
            end
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    REG_PROCESS_NOISE:  q_reg    <= cfg_data;
                    REG_MEASURE_NOISE:  r_reg    <= cfg_data;
                    REG_DIRECTION_MASK: mask_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_UPDX) begin
                est_reg[idx] <= x_new;
            end
            if (state_reg == ST_UPDP) begin
                var_reg[idx] <= var_new;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    ch_reg <= s_data.channel;
                    z_reg  <= z_in;
                end
            end
            ST_LOAD: begin
                x_reg <= x_rd;
                p_reg <= p_sat;
            end
            ST_DENOM: begin
                den_reg  <= den_sum;
                diff_reg <= diff_next;
                rem_reg  <= {2'b00, p_reg};
                k_reg    <= '0;
                cnt_reg  <= '0;
            end
            ST_DIV: begin
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
                // zero denominator gives unity gain
                if (div_last && (den_reg == '0)) begin
                    k_reg <= K_ONE;
                end else begin
                    k_reg <= {k_reg[K_W-2:0], q_bit};
                end
            end
            ST_MULK: begin
                prod_reg <= mul_p;
            end
            ST_UPDX: begin
                x_reg    <= x_new;
                prod_reg <= mul_p;
            end
            ST_FIN: begin
                if (out_load) begin
                    m_data_reg.out_channel    <= ch_reg;
                    m_data_reg.filtered_speed <= res;
                end
            end
            default: ;
        endcase
    end

    // checks
    `SKF_ASSERT_NR(a_reset_empties_output, aclk,
                   !aresetn |=> !m_valid, "result valid after reset")
    `SKF_ASSERT(a_accept_starts_load, aclk, aresetn,
                in_fire |=> state_reg == ST_LOAD, "accepted word not loaded")
    `SKF_ASSERT(a_gain_at_most_one, aclk, aresetn,
                state_reg == ST_MULK |-> k_reg <= K_ONE, "gain above one")
    `SKF_ASSERT(a_variance_shrinks, aclk, aresetn,
                state_reg == ST_UPDP |-> var_new <= p_reg, "variance grew in update")
    `SKF_ASSERT(a_waiting_result_kept, aclk, aresetn,
                (state_reg == ST_FIN) && m_valid && !m_ready |=> state_reg == ST_FIN,
                "result overwritten")

endmodule

// ----- sim/scalar_kalman_speed_filter_tb.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_speed_filter_tb
// Self-checking bench for the per-channel scalar Kalman speed filter. A
// clocked driver feeds sample words from a queue and predicts each filtered
// word on acceptance. A clocked monitor checks every result word against the
// oldest prediction. The register settings change between phases, only while
// the block is idle; random gaps are put on the input and back-pressure on the output.
// ----------------------------------------------------------------------------
module scalar_kalman_speed_filter_tb;
    import skf_pkg::*;

    localparam int              NCH        = CHANNELS_DEF;
    localparam longint          Q16_ONE    = 65536;
    localparam longint unsigned VAR_LIMIT  = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [1:0]      REG_SPARE  = 2'd3;   // unmapped index, write ignored
    localparam int              DRAIN_CYC  = 40;
    localparam int              MAX_SHOWN  = 10;

    // Clock and reset
    logic aclk = 1'b0;
    logic aresetn;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Block ports
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    scalar_kalman_speed_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow registers and per-channel filter state of the predictor
    logic [31:0]     q_noise;
    logic [31:0]     r_noise;
    logic [3:0]      dir_mask;
    longint          est_q16 [NCH];
    longint unsigned var_q16 [NCH];

    // Bench bookkeeping
    in_item_t  sample_queue [$];
    out_item_t pending_speeds [$];
    out_item_t want_word;
    int        idle_pct;
    int        fault_count;
    int        samples_taken;
    int        words_checked;
    int        settings_run;
    int        drift [NCH];

    // One Kalman step on the shadow state; returns the filtered word
    function automatic out_item_t filter_update(input in_item_t smp);
        out_item_t       res;
        int              ch;
        int              raw;
        longint          z;
        longint          x;
        longint          diff;
        longint          quo;
        longint unsigned p;
        longint unsigned den;
        longint unsigned k;
        ch = smp.channel;
        res.out_channel = smp.channel;
        res.filtered_speed = '0;
        if (ch >= NCH) return res;
        raw = $signed(smp.raw_delta);
        // direction sign, most negative count folds to the top
        if (dir_mask[ch]) raw = (raw == -32768) ? 32767 : -raw;
        z = longint'(raw) * Q16_ONE;
        p = var_q16[ch] + {32'd0, q_noise};
        if (p > VAR_LIMIT) p = VAR_LIMIT;
        den = p + {32'd0, r_noise};
        // gain of one when there is nothing to divide by
        if (den == 0) k = Q16_ONE;
        else k = (p << 16) / den;
        x = est_q16[ch];
        diff = z - x;
        x = x + ((longint'(k) * diff) >>> 16);
        est_q16[ch] = x;
        var_q16[ch] = (p * (unsigned'(Q16_ONE) - k)) >> 16;
        quo = x / Q16_ONE;
        if (quo > 32767) quo = 32767;
        if (quo < -32768) quo = -32768;
        res.filtered_speed = 16'(quo);
        return res;
    endfunction

    // Random sample: mostly a drifting speed with jitter, some noise and extremes
    function automatic in_item_t next_sample();
        in_item_t s;
        int       ch;
        int       pick;
        int       v;
        ch = $urandom_range(NCH - 1);
        pick = $urandom_range(99);
        if (pick < 60) begin
            drift[ch] = drift[ch] + int'($urandom_range(400)) - 200;
            if (drift[ch] > 30000) drift[ch] = 30000;
            if (drift[ch] < -30000) drift[ch] = -30000;
            v = drift[ch] + int'($urandom_range(64)) - 32;
        end else if (pick < 88) begin
            v = int'($urandom_range(65535)) - 32768;
        end else begin
            case ($urandom_range(4))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                3: v = -1;
                default: v = 1;
            endcase
        end
        s.channel = 2'(ch);
        s.raw_delta = 16'(v);
        return s;
    endfunction

    task automatic push_sample(input int ch, input int v);
        in_item_t s;
        s.channel = 2'(ch);
        s.raw_delta = 16'(v);
        sample_queue.push_back(s);
    endtask

    task automatic push_random(input int n);
        repeat (n) sample_queue.push_back(next_sample());
    endtask

    // Register write on the configuration channel
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PROCESS_NOISE:  q_noise = val;
            REG_MEASURE_NOISE:  r_noise = val;
            REG_DIRECTION_MASK: dir_mask = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] q, input logic [31:0] r, input logic [3:0] m);
        set_reg(REG_PROCESS_NOISE, q);
        set_reg(REG_MEASURE_NOISE, r);
        set_reg(REG_DIRECTION_MASK, {28'd0, m});
        settings_run++;
    endtask

    // Wait until every queued word has gone in and every result is back
    task automatic wait_drained();
        while (sample_queue.size() > 0 || s_valid || pending_speeds.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_SHOWN) $display("mismatch: %s", msg);
    endtask

    // Sample driver: predicts on acceptance, then offers the next word
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pending_speeds.push_back(filter_update(s_data));
            samples_taken++;
        end
        if (s_valid && !s_ready) begin
            // hold the word until taken
        end else if (sample_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
            s_valid <= 1'b1;
            s_data  <= sample_queue.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result monitor with random back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_speeds.size() == 0) begin
                report_fault($sformatf("unexpected word ch=%0d speed=%0d",
                                       m_data.out_channel, m_data.filtered_speed));
            end else begin
                want_word = pending_speeds.pop_front();
                words_checked++;
                if (m_data.out_channel !== want_word.out_channel ||
                    m_data.filtered_speed !== want_word.filtered_speed)
                    report_fault($sformatf(
                        "word %0d: expected ch=%0d speed=%0d, got ch=%0d speed=%0d",
                        words_checked, want_word.out_channel,
                        want_word.filtered_speed, m_data.out_channel,
                        m_data.filtered_speed));
            end
        end
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Stimulus and end of run
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PROCESS_NOISE;
        cfg_data  = '0;
        idle_pct  = 24;
        fault_count   = 0;
        samples_taken = 0;
        words_checked = 0;
        settings_run  = 1;
        q_noise  = Q_RESET;
        r_noise  = R_RESET;
        dir_mask = MASK_RESET;
        for (int i = 0; i < NCH; i++) begin
            est_q16[i] = 0;
            var_q16[i] = VAR_RESET;
            drift[i]   = 0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset settings: extremes on negated and plain channels
        push_sample(0, -32768);
        push_sample(1, -32768);
        push_sample(2, 32767);
        push_sample(3, 32767);
        push_sample(0, 0);
        push_sample(1, 1);
        push_sample(2, -1);
        push_sample(3, 0);
        push_sample(1, 32767);
        push_sample(0, 32767);
        push_sample(3, -32768);
        push_sample(2, -32768);
        wait_drained();

        // No noise at all: unit gain, then an empty denominator
        set_all(32'd0, 32'd0, 4'hF);
        push_sample(0, -32768);
        push_sample(0, 1234);
        push_sample(1, -32768);
        push_sample(1, -500);
        push_sample(2, 32767);
        push_sample(3, -7);
        push_sample(3, 0);
        push_sample(2, -32768);
        wait_drained();

        // Largest noise on both sides, no channel negated
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);
        push_random(80);
        wait_drained();

        // Slow filter, no idling on either side
        idle_pct = 0;
        set_all(32'd1, 32'hFFFF_FFFF, 4'hA);
        push_random(80);
        wait_drained();
        idle_pct = 24;

        // Random settings, plus a write to the unmapped index
        set_all($urandom, $urandom_range(32'h00FF_FFFF), 4'($urandom_range(15)));
        set_reg(REG_SPARE, $urandom);
        push_random(80);
        wait_drained();

        // Back to the power-on figures
        set_all(Q_RESET, R_RESET, MASK_RESET);
        push_random(80);
        wait_drained();

        // Large process noise, no measurement noise
        set_all(32'hFFFF_FFFF, 32'd0, 4'($urandom_range(15)));
        push_random(80);
        wait_drained();

        $display("checked %0d filtered words from %0d samples over %0d register settings",
                 words_checked, samples_taken, settings_run);
        $display("%0d mismatches, %0d results still outstanding",
                 fault_count, pending_speeds.size());
        if (fault_count == 0 && pending_speeds.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
